// ===== hw/rtl/kr_pkg.sv =====
// kr_pkg: shared types and constants of the typematic repeater
// used by kr_front, kr_fifo, kr_back and key_typematic_repeater; no dependencies
package kr_pkg;

	// largest burst one dispatch may emit
	localparam int unsigned MAX_BURST = 8;
	localparam int unsigned BURST_W   = $clog2(MAX_BURST + 1);

	// burst queue between front and back
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

	// field widths
	localparam int unsigned CODE_W  = 10;
	localparam int unsigned STAMP_W = 32;
	localparam int unsigned CFG_W   = 16;
	localparam int unsigned CIDX_W  = 2;

	// register reset values
	localparam logic [CFG_W-1:0] DELAY_RST    = 16'd500;
	localparam logic [CFG_W-1:0] INTERVAL_RST = 16'd33;
	localparam logic [CFG_W-1:0] PENDING_MAX  = 16'hFFFF;

	// configuration register indexes
	typedef enum logic [CIDX_W-1:0] {
		REG_DELAY    = 2'd0,
		REG_INTERVAL = 2'd1
	} reg_idx_t;

	// input item kinds
	typedef enum logic [1:0] {
		KIND_KEY      = 2'd0,
		KIND_TICK     = 2'd1,
		KIND_DISPATCH = 2'd2,
		KIND_CANCEL   = 2'd3
	} kind_t;

	// one dispatch worth of repeats
	typedef struct packed {
		logic [CODE_W-1:0]  code;
		logic [STAMP_W-1:0] stamp;
		logic [BURST_W-1:0] count;
	} burst_t;

	// push side of the burst queue
	typedef struct packed {
		logic   valid;
		burst_t burst;
	} push_t;

endpackage

// ===== hw/rtl/kr_front.sv =====
// kr_front: accepts transactions, keeps the timer state and configuration
// depends on kr_pkg; pushes burst descriptors towards kr_fifo
module kr_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   kind,
	input  logic [kr_pkg::CODE_W-1:0]    key_code,
	input  logic                         is_press,
	input  logic                         is_synthetic,
	input  logic                         may_repeat,
	input  logic                         cfg_we,
	input  logic [kr_pkg::CIDX_W-1:0]    cfg_index,
	input  logic [kr_pkg::CFG_W-1:0]     cfg_data,
	input  logic                         q_full,
	output kr_pkg::push_t                push
);

	logic [kr_pkg::CFG_W-1:0]   delay_q;
	logic [kr_pkg::CFG_W-1:0]   interval_q;
	logic [kr_pkg::CODE_W-1:0]  held_code_q;
	logic                       holding_q;
	logic                       armed_q;
	logic [kr_pkg::CFG_W-1:0]   tte_q;
	logic [kr_pkg::CFG_W-1:0]   pending_q;
	logic [kr_pkg::STAMP_W-1:0] clock_q;

	logic                       accept;
	logic [kr_pkg::CFG_W-1:0]   eff_interval;
	logic [kr_pkg::BURST_W-1:0] burst_count;
	kr_pkg::kind_t              kind_e;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign kind_e   = kr_pkg::kind_t'(kind);

	// an interval of zero behaves as one tick
	assign eff_interval = (interval_q == '0) ? kr_pkg::CFG_W'(1) : interval_q;

	// pending count clipped to the burst limit
	assign burst_count = (pending_q > kr_pkg::CFG_W'(kr_pkg::MAX_BURST))
		? kr_pkg::BURST_W'(kr_pkg::MAX_BURST) : pending_q[kr_pkg::BURST_W-1:0];

	// burst descriptor for a dispatch while a key is held and repeats are pending
	always_comb begin
		push.valid       = accept && (kind_e == kr_pkg::KIND_DISPATCH) && holding_q
			&& (burst_count != '0);
		push.burst.code  = held_code_q;
		push.burst.stamp = clock_q;
		push.burst.count = burst_count;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q    <= kr_pkg::DELAY_RST;
			interval_q <= kr_pkg::INTERVAL_RST;
		end else if (cfg_we) begin
			if (cfg_index == kr_pkg::REG_DELAY) begin
				delay_q <= cfg_data;
			end
			if (cfg_index == kr_pkg::REG_INTERVAL) begin
				interval_q <= cfg_data;
			end
		end
	end

	// timer state update per transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_code_q <= '0;
			holding_q   <= 1'b0;
			armed_q     <= 1'b0;
			tte_q       <= '0;
			pending_q   <= '0;
			clock_q     <= '0;
		end else if (accept) begin
			unique case (kind_e)
				kr_pkg::KIND_KEY: begin
					if (!is_synthetic) begin
						if (is_press) begin
							if (may_repeat) begin
								held_code_q <= key_code;
								holding_q   <= 1'b1;
								armed_q     <= 1'b1;
								if (delay_q == '0) begin
									pending_q <= kr_pkg::CFG_W'(1);
									tte_q     <= eff_interval;
								end else begin
									pending_q <= '0;
									tte_q     <= delay_q;
								end
							end
						end else if (holding_q && (key_code == held_code_q)) begin
							held_code_q <= '0;
							holding_q   <= 1'b0;
							armed_q     <= 1'b0;
							tte_q       <= '0;
							pending_q   <= '0;
						end
					end
				end
				kr_pkg::KIND_TICK: begin
					clock_q <= clock_q + kr_pkg::STAMP_W'(1);
					if (armed_q) begin
						if (tte_q <= kr_pkg::CFG_W'(1)) begin
							if (pending_q != kr_pkg::PENDING_MAX) begin
								pending_q <= pending_q + kr_pkg::CFG_W'(1);
							end
							tte_q <= eff_interval;
						end else begin
							tte_q <= tte_q - kr_pkg::CFG_W'(1);
						end
					end
				end
				kr_pkg::KIND_DISPATCH: begin
					pending_q <= '0;
				end
				kr_pkg::KIND_CANCEL: begin
					held_code_q <= '0;
					holding_q   <= 1'b0;
					armed_q     <= 1'b0;
					tte_q       <= '0;
					pending_q   <= '0;
				end
				default: begin
					pending_q <= pending_q;
				end
			endcase
		end
	end

endmodule

// ===== hw/rtl/kr_fifo.sv =====
// kr_fifo: small queue of burst descriptors between front and back
// depends on kr_pkg
module kr_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  kr_pkg::push_t  push,
	output logic           full,
	input  logic           pop,
	output logic           rd_valid,
	output kr_pkg::burst_t rd_burst
);

	kr_pkg::burst_t               mem [kr_pkg::QUEUE_DEPTH];
	logic [kr_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [kr_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [kr_pkg::QPTR_W:0]      fill_q;
	logic                         do_pop;

	assign full     = (fill_q == (kr_pkg::QPTR_W + 1)'(kr_pkg::QUEUE_DEPTH));
	assign rd_valid = (fill_q != '0);
	assign rd_burst = mem[rd_ptr_q];
	assign do_pop   = pop && rd_valid;

	// storage
	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem[wr_ptr_q] <= push.burst;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= wr_ptr_q + kr_pkg::QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + kr_pkg::QPTR_W'(1);
			end
			priority if (push.valid && !do_pop) begin
				fill_q <= fill_q + (kr_pkg::QPTR_W + 1)'(1);
			end else if (do_pop && !push.valid) begin
				fill_q <= fill_q - (kr_pkg::QPTR_W + 1)'(1);
			end else begin
				fill_q <= fill_q;
			end
		end
	end

endmodule

// ===== hw/rtl/kr_back.sv =====
// kr_back: expands burst descriptors into repeat results, one per cycle while out_ready is high
// depends on kr_pkg; output fields come straight from registers, last_of_burst from a compare
module kr_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_valid,
	input  kr_pkg::burst_t             q_burst,
	output logic                       q_pop,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [kr_pkg::CODE_W-1:0]  repeat_key,
	output logic [kr_pkg::STAMP_W-1:0] stamp_ms,
	output logic                       last_of_burst
);

	logic                       active_q;
	logic [kr_pkg::CODE_W-1:0]  code_q;
	logic [kr_pkg::STAMP_W-1:0] stamp_q;
	logic [kr_pkg::BURST_W-1:0] left_q;
	logic                       is_last;

	assign is_last       = (left_q == kr_pkg::BURST_W'(1));
	assign out_valid     = active_q;
	assign repeat_key    = code_q;
	assign stamp_ms      = stamp_q;
	assign last_of_burst = is_last;

	// take the next descriptor when idle or as the final repeat leaves
	assign q_pop = !active_q || (out_ready && is_last);

	// burst control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			left_q   <= '0;
		end else if (q_pop) begin
			active_q <= q_valid;
			left_q   <= q_burst.count;
		end else if (out_ready) begin
			left_q <= left_q - kr_pkg::BURST_W'(1);
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (q_pop) begin
			code_q  <= q_burst.code;
			stamp_q <= q_burst.stamp;
		end
	end

endmodule

// ===== hw/rtl/key_typematic_repeater.sv =====
// key_typematic_repeater: top level of the typematic auto-repeat timer
// depends on kr_pkg, kr_front, kr_fifo and kr_back
//
// channel   direction  handshake            payload
// in        to block   in_valid / in_ready  kind, key_code, is_press, is_synthetic, may_repeat
// out       from block out_valid / out_ready repeat_key, stamp_ms, last_of_burst
// cfg       to block   cfg_we               cfg_index, cfg_data
//
// one transaction per cycle while in_ready is high; its state update completes in that cycle
// the back end emits one repeat per cycle while out_ready is high, one to eight per dispatch
// in_ready drops only while the four-entry burst queue is full
// reset loads delay 500 and interval 33 and clears timer, clock and queue
module key_typematic_repeater (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [1:0]                 kind,
	input  logic [kr_pkg::CODE_W-1:0]  key_code,
	input  logic                       is_press,
	input  logic                       is_synthetic,
	input  logic                       may_repeat,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [kr_pkg::CODE_W-1:0]  repeat_key,
	output logic [kr_pkg::STAMP_W-1:0] stamp_ms,
	output logic                       last_of_burst,
	input  logic                       cfg_we,
	input  logic [kr_pkg::CIDX_W-1:0]  cfg_index,
	input  logic [kr_pkg::CFG_W-1:0]   cfg_data
);

	kr_pkg::push_t  push;
	kr_pkg::burst_t q_burst;
	logic           q_full;
	logic           q_valid;
	logic           q_pop;

	// classification and timer
	kr_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.kind         (kind),
		.key_code     (key_code),
		.is_press     (is_press),
		.is_synthetic (is_synthetic),
		.may_repeat   (may_repeat),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.q_full       (q_full),
		.push         (push)
	);

	// burst queue
	kr_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (q_full),
		.pop      (q_pop),
		.rd_valid (q_valid),
		.rd_burst (q_burst)
	);

	// burst expansion
	kr_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_burst       (q_burst),
		.q_pop         (q_pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.repeat_key    (repeat_key),
		.stamp_ms      (stamp_ms),
		.last_of_burst (last_of_burst)
	);

endmodule
